@@ sv/gfba_pkg.sv @@
// Shared types and codes for the grouped free-block allocator.
// Used by grouped_free_block_allocator; no dependencies.
package gfba_pkg;

    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;

    typedef logic [BLOCK_W-1:0]  t_block;
    typedef logic [STATUS_W-1:0] t_status;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_NO_SPACE = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

endpackage

@@ sv/gfba_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gfba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/grouped_free_block_allocator.sv @@
// Pops, plain pushes and refusals go through RESP to the result register; a request that
// loads or flushes a group first copies it in LOAD or FLUSH, one word copied per cycle.
// One request at a time: the input stalls until the result is registered, and longer while
// the result side stalls.
// Reset (sync, active low): stack empty, group pointer 0; table reads as its index until
// first written back (a high-water mark of loaded groups stands in for a clearing pass).
module grouped_free_block_allocator #(
    parameter int GROUP_SIZE  = 16,
    parameter int GROUP_COUNT = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic [9:0]              i_freed_block,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [9:0]              o_granted_block,
    output logic [1:0]              o_status
);

    localparam int CW = $clog2(GROUP_SIZE + 1);
    localparam int SW = $clog2(GROUP_SIZE);
    localparam int PW = $clog2(GROUP_COUNT + 1);
    localparam int TD = GROUP_COUNT * GROUP_SIZE;
    localparam int TW = $clog2(TD);

    localparam logic [CW-1:0] GS_C  = CW'(GROUP_SIZE);
    localparam logic [CW-1:0] GS_M1 = CW'(GROUP_SIZE - 1);
    localparam logic [PW-1:0] GC_P  = PW'(GROUP_COUNT);
    localparam logic [TW-1:0] GS_T  = TW'(GROUP_SIZE);

    gfba_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_ptr, n_ptr;
    logic [PW-1:0]     r_hw, n_hw;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [TW-1:0]     r_taddr, n_taddr;
    logic [TW-1:0]     r_prev, n_prev;
    logic              r_fresh, n_fresh;
    logic              r_use_rd, n_use_rd;
    gfba_pkg::t_block  r_grant, n_grant;
    gfba_pkg::t_status r_status, n_status;
    gfba_pkg::t_block  r_out_grant, n_out_grant;
    gfba_pkg::t_status r_out_status, n_out_status;

    logic              stk_we, stk_re;
    logic [SW-1:0]     stk_waddr, stk_raddr;
    gfba_pkg::t_block  stk_wdata, stk_rd;
    logic              tbl_we, tbl_re;
    logic [TW-1:0]     tbl_waddr, tbl_raddr;
    gfba_pkg::t_block  tbl_wdata, tbl_rd;

    logic [CW-1:0]     idx_m1, cnt_m1;
    gfba_pkg::t_block  ld_data;
    logic              out_free;

    // Free-block stack
    gfba_ram #(.WIDTH(gfba_pkg::BLOCK_W), .DEPTH(GROUP_SIZE)) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_en   (stk_re),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rd)
    );

    // Group table
    gfba_ram #(.WIDTH(gfba_pkg::BLOCK_W), .DEPTH(TD)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_waddr),
        .i_wr_data (tbl_wdata),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_raddr),
        .o_rd_data (tbl_rd)
    );

    // Sequencer and datapath next values
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_hw         = r_hw;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_taddr      = r_taddr;
        n_prev       = r_prev;
        n_fresh      = r_fresh;
        n_use_rd     = r_use_rd;
        n_grant      = r_grant;
        n_status     = r_status;
        n_out_grant  = r_out_grant;
        n_out_status = r_out_status;
        stk_we       = 1'b0;
        stk_waddr    = '0;
        stk_wdata    = '0;
        stk_re       = 1'b0;
        stk_raddr    = '0;
        tbl_we       = 1'b0;
        tbl_waddr    = '0;
        tbl_wdata    = '0;
        tbl_re       = 1'b0;
        tbl_raddr    = '0;

        idx_m1   = r_idx - CW'(1);
        cnt_m1   = r_count - CW'(1);
        // A group never written back still reads as its own slot index
        ld_data  = r_fresh ? gfba_pkg::t_block'(r_prev) : tbl_rd;
        out_free = !r_out_valid || !i_out_stall;

        // Drop the output beat once taken
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            gfba_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == gfba_pkg::FUNC_ALLOC) begin
                        if (r_count == '0) begin
                            if (r_ptr == GC_P) begin
                                n_grant  = '0;
                                n_status = gfba_pkg::STATUS_NO_SPACE;
                                n_use_rd = 1'b0;
                                n_state  = gfba_pkg::ST_RESP;
                            end else begin
                                n_taddr = TW'(r_ptr) * GS_T;
                                n_fresh = (r_ptr == r_hw);
                                n_idx   = '0;
                                n_state = gfba_pkg::ST_LOAD;
                            end
                        end else begin
                            // Pop the stack top
                            stk_re    = 1'b1;
                            stk_raddr = cnt_m1[SW-1:0];
                            n_count   = cnt_m1;
                            n_use_rd  = 1'b1;
                            n_status  = gfba_pkg::STATUS_OK;
                            n_state   = gfba_pkg::ST_RESP;
                        end
                    end else begin
                        if (r_count >= GS_M1 && r_ptr == '0) begin
                            n_grant  = '0;
                            n_status = gfba_pkg::STATUS_OVERFLOW;
                            n_use_rd = 1'b0;
                            n_state  = gfba_pkg::ST_RESP;
                        end else begin
                            // Push the freed block
                            stk_we    = 1'b1;
                            stk_waddr = r_count[SW-1:0];
                            stk_wdata = i_freed_block;
                            if (r_count >= GS_M1) begin
                                n_ptr   = r_ptr - PW'(1);
                                n_taddr = TW'(r_ptr - PW'(1)) * GS_T;
                                n_idx   = '0;
                                n_state = gfba_pkg::ST_FLUSH;
                            end else begin
                                n_count  = r_count + CW'(1);
                                n_grant  = '0;
                                n_status = gfba_pkg::STATUS_OK;
                                n_use_rd = 1'b0;
                                n_state  = gfba_pkg::ST_RESP;
                            end
                        end
                    end
                end
            end

            gfba_pkg::ST_LOAD: begin
                // Issue table reads, write each word into the stack once its registered read returns
                if (r_idx != GS_C) begin
                    tbl_re    = 1'b1;
                    tbl_raddr = r_taddr;
                    n_prev    = r_taddr;
                    n_taddr   = r_taddr + TW'(1);
                end
                if (r_idx != '0) begin
                    stk_we    = 1'b1;
                    stk_waddr = idx_m1[SW-1:0];
                    stk_wdata = ld_data;
                end
                if (r_idx == GS_C) begin
                    // The last word loaded is the top, hand it out directly
                    n_grant  = ld_data;
                    n_status = gfba_pkg::STATUS_OK;
                    n_use_rd = 1'b0;
                    n_count  = GS_M1;
                    n_ptr    = r_ptr + PW'(1);
                    if (r_fresh) begin
                        n_hw = r_ptr + PW'(1);
                    end
                    n_state  = gfba_pkg::ST_RESP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            gfba_pkg::ST_FLUSH: begin
                // Read stack words, write each into the group once its registered read returns
                if (r_idx != GS_C) begin
                    stk_re    = 1'b1;
                    stk_raddr = r_idx[SW-1:0];
                end
                if (r_idx != '0) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_taddr;
                    tbl_wdata = stk_rd;
                    n_taddr   = r_taddr + TW'(1);
                end
                if (r_idx == GS_C) begin
                    n_count  = '0;
                    n_grant  = '0;
                    n_status = gfba_pkg::STATUS_OK;
                    n_use_rd = 1'b0;
                    n_state  = gfba_pkg::ST_RESP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            gfba_pkg::ST_RESP: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_grant  = r_use_rd ? stk_rd : r_grant;
                    n_out_status = r_status;
                    n_state      = gfba_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gfba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfba_pkg::ST_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_hw        <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_hw        <= n_hw;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_taddr      <= n_taddr;
        r_prev       <= n_prev;
        r_fresh      <= n_fresh;
        r_use_rd     <= n_use_rd;
        r_grant      <= n_grant;
        r_status     <= n_status;
        r_out_grant  <= n_out_grant;
        r_out_status <= n_out_status;
    end

    assign o_in_stall      = (r_state != gfba_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_granted_block = r_out_grant;
    assign o_status        = r_out_status;

    // Between requests the stack never holds a full group
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfba_pkg::ST_IDLE) |-> (r_count < GS_C))
        else $error("stack count reached group size while idle");

    // Group pointer and high-water mark stay within the table, pointer at or below the mark
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr <= GC_P) && (r_ptr <= r_hw) && (r_hw <= GC_P))
        else $error("group pointer or high-water mark out of range");

    // An accepted beat always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != gfba_pkg::ST_IDLE))
        else $error("accepted request did not leave idle");

    // The copy counter never runs past one group
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfba_pkg::ST_LOAD || r_state == gfba_pkg::ST_FLUSH) |-> (r_idx <= GS_C))
        else $error("copy index ran past group size");

endmodule
